[hdl/imh_pkg.sv]
package imh_pkg;

  localparam int VERTEX_W     = 10;
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 11;
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 32;

  typedef enum logic [1:0] {
    OP_SET_KEY = 2'd0,
    OP_BUILD   = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_RD,
    S_SET_CHK,
    S_UP,
    S_PLACE,
    S_BUILD,
    S_BUILD_TAIL,
    S_HEAP_NEXT,
    S_LOAD,
    S_DOWN,
    S_EXT_RD,
    S_EXT_CHK,
    S_FIN_RD,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t                 opcode;
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    new_key;
    logic [COUNT_W-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] min_vertex;
    logic [KEY_W-1:0]    min_key;
    logic                is_empty;
    logic                is_present;
    logic                underflow;
  } rsp_t;

endpackage

[hdl/imh_ifs.sv]
interface imh_req_if;
  logic          valid;
  logic          ready;
  imh_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imh_rsp_if;
  logic          valid;
  logic          ready;
  imh_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/indexed_min_heap_core.sv]
// Channel  Role   Handshake      Payload
// req      sink   valid/ready    opcode, vertex, new_key, count
// rsp      source valid/ready    min_vertex, min_key, is_empty, is_present, underflow
//
// One request at a time, from the accepting cycle until the core is idle again. Query and
// extract on an empty heap go straight to the response; set_key writes the key and, on a
// present vertex, climbs level by level; extract_min descends level by level; build passes
// over all CAPACITY vertices, then sifts each parent down level by level.
// After reset the position map is cleared; no request is taken then.
// A finished response waits in an output register; the core takes the next request
// meanwhile and stalls only when a second response is ready before the first is taken.
module indexed_min_heap_core #(
  parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS
) (
  input logic      clk,
  input logic      rst,
  imh_req_if.sink  req,
  imh_rsp_if.source rsp
);

  localparam int VW = $clog2(CAPACITY);
  localparam int SW = VW + 1;
  localparam int CW = VW + 2;
  localparam int KB = KEY_BITS;
  localparam int EW = VW + KB;
  localparam int PW = VW + 1;
  localparam logic [VW-1:0] LAST = VW'(CAPACITY - 1);

  imh_pkg::state_t state, state_next;

  imh_pkg::op_t           op;
  logic [imh_pkg::VERTEX_W-1:0] vtx;
  logic [KB-1:0]          nkey;
  logic [SW-1:0]          cnt;
  logic [SW-1:0]          size;
  logic [SW-1:0]          hi;
  logic                   v_ok;
  logic [VW-1:0]          s;
  logic [VW-1:0]          x_v;
  logic [KB-1:0]          x_k;
  logic [VW-1:0]          c;
  logic                   wr_pend;
  logic [VW-1:0]          wr_idx;
  logic [imh_pkg::VERTEX_W-1:0] mv;
  logic [imh_pkg::KEY_W-1:0]    mk;
  logic                   uf;
  logic                   out_valid;
  imh_pkg::rsp_t          out_q;

  // Heap slot memory: {vertex, key} per slot, two read ports for the two children.
  logic          heap_we, heap_rea, heap_reb;
  logic [VW-1:0] heap_wa, heap_aa, heap_ab;
  logic [EW-1:0] heap_wd, heap_rda, heap_rdb;
  // Position map: {present, slot} per vertex.
  logic          pos_we, pos_re;
  logic [VW-1:0] pos_wa, pos_ra;
  logic [PW-1:0] pos_wd, pos_rd;
  // Key per vertex.
  logic          key_we, key_re;
  logic [VW-1:0] key_wa, key_ra;
  logic [KB-1:0] key_wd, key_rd;

  logic          accept, out_load;
  logic [VW-1:0] vidx;
  logic [CW-1:0] lw, rw;
  logic          lok, rok;
  logic [KB-1:0] a_k, b_k, bk;
  logic [1:0]    bsel;
  logic          down_move;
  logic [VW-1:0] best_slot;
  logic [EW-1:0] best_ent;
  logic [VW-1:0] p;
  logic          up_move;
  logic          wr_lt;

  function automatic logic [VW-1:0] left_of(input logic [VW-1:0] a);
    left_of = VW'({a, 1'b1});
  endfunction

  function automatic logic [VW-1:0] right_of(input logic [VW-1:0] a);
    logic [CW-1:0] t;
    t = CW'({a, 1'b1}) + CW'(1);
    right_of = VW'(t);
  endfunction

  function automatic logic [VW-1:0] parent_of(input logic [VW-1:0] a);
    parent_of = VW'((a - VW'(1)) >> 1);
  endfunction

  imh_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
    .re_a(heap_rea), .raddr_a(heap_aa), .rdata_a(heap_rda),
    .re_b(heap_reb), .raddr_b(heap_ab), .rdata_b(heap_rdb)
  );

  imh_ram #(.DEPTH(CAPACITY), .WIDTH(PW)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
    .re_a(pos_re), .raddr_a(pos_ra), .rdata_a(pos_rd),
    .re_b(1'b0), .raddr_b('0), .rdata_b()
  );

  imh_ram #(.DEPTH(CAPACITY), .WIDTH(KB)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
    .re_a(key_re), .raddr_a(key_ra), .rdata_a(key_rd),
    .re_b(1'b0), .raddr_b('0), .rdata_b()
  );

  assign req.ready = (state == imh_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == imh_pkg::S_FIN) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;
  assign vidx      = VW'(vtx);
  assign wr_lt     = SW'(wr_idx) < cnt;

  // Sift decisions. The moving element is held in x_v/x_k; the slot it vacates
  // takes the winning neighbor, so only the final slot receives x.
  always_comb begin
    lw  = CW'({s, 1'b1});
    rw  = lw + CW'(1);
    lok = lw < CW'(size);
    rok = rw < CW'(size);
    a_k = heap_rda[KB-1:0];
    b_k = heap_rdb[KB-1:0];
    bk  = x_k;
    bsel = 2'd0;
    if (lok && (a_k < bk)) begin
      bk   = a_k;
      bsel = 2'd1;
    end
    if (rok && (b_k < bk)) begin
      bsel = 2'd2;
    end
    down_move = (bsel != 2'd0);
    best_slot = (bsel == 2'd2) ? VW'(rw) : VW'(lw);
    best_ent  = (bsel == 2'd2) ? heap_rdb : heap_rda;
    p         = parent_of(s);
    up_move   = x_k < a_k;
  end

  always_comb begin
    state_next = state;
    case (state)
      imh_pkg::S_CLEAR: begin
        if (c == LAST) state_next = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: begin
        if (accept) begin
          case (req.data.opcode)
            imh_pkg::OP_SET_KEY: state_next = imh_pkg::S_SET_RD;
            imh_pkg::OP_BUILD:   state_next = imh_pkg::S_BUILD;
            imh_pkg::OP_EXTRACT: state_next = (size == '0) ? imh_pkg::S_FIN_RD
                                                           : imh_pkg::S_EXT_RD;
            default:             state_next = imh_pkg::S_FIN_RD;
          endcase
        end
      end
      imh_pkg::S_SET_RD: state_next = v_ok ? imh_pkg::S_SET_CHK : imh_pkg::S_FIN_RD;
      imh_pkg::S_SET_CHK: begin
        if (!pos_rd[VW]) state_next = imh_pkg::S_FIN_RD;
        else if (pos_rd[VW-1:0] == '0) state_next = imh_pkg::S_PLACE;
        else state_next = imh_pkg::S_UP;
      end
      imh_pkg::S_UP: begin
        if (!up_move) state_next = imh_pkg::S_FIN_RD;
        else if (p == '0) state_next = imh_pkg::S_PLACE;
      end
      imh_pkg::S_PLACE:      state_next = imh_pkg::S_FIN_RD;
      imh_pkg::S_BUILD: begin
        if (c == LAST) state_next = imh_pkg::S_BUILD_TAIL;
      end
      imh_pkg::S_BUILD_TAIL: state_next = imh_pkg::S_HEAP_NEXT;
      imh_pkg::S_HEAP_NEXT:  state_next = (hi == '0) ? imh_pkg::S_FIN_RD : imh_pkg::S_LOAD;
      imh_pkg::S_LOAD:       state_next = imh_pkg::S_DOWN;
      imh_pkg::S_DOWN: begin
        if (!down_move) begin
          state_next = (op == imh_pkg::OP_BUILD) ? imh_pkg::S_HEAP_NEXT : imh_pkg::S_FIN_RD;
        end
      end
      imh_pkg::S_EXT_RD:     state_next = imh_pkg::S_EXT_CHK;
      imh_pkg::S_EXT_CHK:    state_next = (size > SW'(1)) ? imh_pkg::S_DOWN : imh_pkg::S_FIN_RD;
      imh_pkg::S_FIN_RD:     state_next = imh_pkg::S_FIN;
      imh_pkg::S_FIN: begin
        if (out_load) state_next = imh_pkg::S_IDLE;
      end
      default:               state_next = imh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    heap_we = 1'b0; heap_wa = s; heap_wd = {x_v, x_k};
    heap_rea = 1'b0; heap_aa = '0; heap_reb = 1'b0; heap_ab = '0;
    pos_we = 1'b0; pos_wa = x_v; pos_wd = {1'b1, s};
    pos_re = 1'b0; pos_ra = vidx;
    key_we = 1'b0; key_wa = vidx; key_wd = nkey;
    key_re = 1'b0; key_ra = c;
    case (state)
      imh_pkg::S_CLEAR: begin
        pos_we = 1'b1;
        pos_wa = c;
        pos_wd = '0;
      end
      imh_pkg::S_SET_RD: begin
        key_we = v_ok;
        pos_re = 1'b1;
      end
      imh_pkg::S_SET_CHK: begin
        heap_rea = 1'b1;
        heap_aa  = parent_of(pos_rd[VW-1:0]);
      end
      imh_pkg::S_UP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (up_move) begin
          heap_wd  = heap_rda;
          pos_wa   = heap_rda[EW-1:KB];
          heap_rea = 1'b1;
          heap_aa  = parent_of(p);
        end
      end
      imh_pkg::S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      imh_pkg::S_BUILD, imh_pkg::S_BUILD_TAIL: begin
        key_re  = (state == imh_pkg::S_BUILD);
        pos_we  = wr_pend;
        pos_wa  = wr_idx;
        pos_wd  = {wr_lt, wr_idx};
        heap_we = wr_pend && wr_lt;
        heap_wa = wr_idx;
        heap_wd = {wr_idx, key_rd};
      end
      imh_pkg::S_HEAP_NEXT: begin
        heap_rea = 1'b1;
        heap_aa  = VW'(hi - SW'(1));
      end
      imh_pkg::S_LOAD: begin
        heap_rea = 1'b1;
        heap_aa  = left_of(s);
        heap_reb = 1'b1;
        heap_ab  = right_of(s);
      end
      imh_pkg::S_DOWN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (down_move) begin
          heap_wd  = best_ent;
          pos_wa   = best_ent[EW-1:KB];
          heap_rea = 1'b1;
          heap_aa  = left_of(best_slot);
          heap_reb = 1'b1;
          heap_ab  = right_of(best_slot);
        end
      end
      imh_pkg::S_EXT_RD: begin
        heap_rea = 1'b1;
        heap_aa  = '0;
        heap_reb = 1'b1;
        heap_ab  = VW'(size - SW'(1));
      end
      imh_pkg::S_EXT_CHK: begin
        pos_we   = 1'b1;
        pos_wa   = heap_rda[EW-1:KB];
        pos_wd   = '0;
        heap_rea = 1'b1;
        heap_aa  = left_of('0);
        heap_reb = 1'b1;
        heap_ab  = right_of('0);
      end
      imh_pkg::S_FIN_RD: begin
        pos_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imh_pkg::S_CLEAR;
      c         <= '0;
      size      <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      case (state)
        imh_pkg::S_CLEAR: c <= c + VW'(1);
        imh_pkg::S_IDLE: begin
          if (accept) begin
            op   <= req.data.opcode;
            vtx  <= req.data.vertex;
            nkey <= KB'(req.data.new_key);
            v_ok <= 32'(req.data.vertex) < 32'(CAPACITY);
            cnt  <= (32'(req.data.count) > 32'(CAPACITY)) ? SW'(CAPACITY)
                                                           : SW'(req.data.count);
            mv   <= '0;
            mk   <= '0;
            uf   <= (req.data.opcode == imh_pkg::OP_EXTRACT) && (size == '0);
            c    <= '0;
          end
        end
        imh_pkg::S_SET_CHK: begin
          s   <= pos_rd[VW-1:0];
          x_v <= vidx;
          x_k <= nkey;
        end
        imh_pkg::S_UP: begin
          if (up_move) s <= p;
        end
        imh_pkg::S_BUILD: begin
          c       <= c + VW'(1);
          wr_idx  <= c;
          wr_pend <= 1'b1;
        end
        imh_pkg::S_BUILD_TAIL: begin
          wr_pend <= 1'b0;
          size    <= cnt;
          hi      <= cnt >> 1;
        end
        imh_pkg::S_HEAP_NEXT: begin
          if (hi != '0) begin
            s  <= VW'(hi - SW'(1));
            hi <= hi - SW'(1);
          end
        end
        imh_pkg::S_LOAD: begin
          x_v <= heap_rda[EW-1:KB];
          x_k <= heap_rda[KB-1:0];
        end
        imh_pkg::S_DOWN: begin
          if (down_move) s <= best_slot;
        end
        imh_pkg::S_EXT_CHK: begin
          mv   <= imh_pkg::VERTEX_W'(heap_rda[EW-1:KB]);
          mk   <= imh_pkg::KEY_W'(heap_rda[KB-1:0]);
          size <= size - SW'(1);
          x_v  <= heap_rdb[EW-1:KB];
          x_k  <= heap_rdb[KB-1:0];
          s    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q.min_vertex <= mv;
      out_q.min_key    <= mk;
      out_q.is_empty   <= (size == '0);
      out_q.is_present <= v_ok && pos_rd[VW];
      out_q.underflow  <= uf;
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= SW'(CAPACITY))
    else $error("heap size above capacity");

  a_underflow_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.underflow |->
      rsp.data.is_empty && (rsp.data.min_vertex == '0) && (rsp.data.min_key == '0))
    else $error("underflow response carries data");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (rst)
    heap_we && (state == imh_pkg::S_DOWN || state == imh_pkg::S_UP ||
                state == imh_pkg::S_PLACE) |-> SW'(s) < size)
    else $error("sift writes outside the heap");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second request taken while one is in progress");

endmodule

[hdl/imh_ram.sv]
module imh_ram #(
  parameter int DEPTH = imh_pkg::DEF_CAPACITY,
  parameter int WIDTH = imh_pkg::KEY_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
